FILE: sv/bps_pkg.sv
// Shared types, widths and helper functions for the ball physics step block.
// Used by the serial arithmetic units and by the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package bps_pkg;

    // Serial multiplier operand widths: magnitude A and bit-serial operand B.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 29;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Squared distance, its root and the divider operands.
    localparam int SQ_IN_W   = 58;
    localparam int SQ_OUT_W  = 29;
    localparam int DIV_N_W   = 58;
    localparam int DIV_D_W   = 29;

    localparam int POS_W  = 28;
    localparam int VEL_W  = 32;
    localparam int WIDE_W = 40;
    localparam int Q16    = 16;

    // Configuration register indexes.
    localparam logic [2:0] REG_ARENA_W   = 3'd0;
    localparam logic [2:0] REG_ARENA_H   = 3'd1;
    localparam logic [2:0] REG_RADIUS    = 3'd2;
    localparam logic [2:0] REG_GRAVITY   = 3'd3;
    localparam logic [2:0] REG_PULL      = 3'd4;
    localparam logic [2:0] REG_DAMPING   = 3'd5;
    localparam logic [2:0] REG_RESTITUTE = 3'd6;

    typedef enum logic [4:0] {
        ST_IDLE, ST_GRAV, ST_DX2, ST_DY2, ST_SQRT, ST_PULL,
        ST_NUMX, ST_DIVX, ST_NUMY, ST_DIVY, ST_MOVX, ST_MOVY,
        ST_DAMP, ST_WALL, ST_RSTX, ST_RSTY, ST_FIN
    } state_t;

    // Handshake between the sequencer and one serial unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    // Scale a signed product down by 16 bits, rounding half up.
    function automatic logic signed [63:0] round_q16(input logic signed [63:0] v);
        logic signed [63:0] s;
        begin
            s = v + 64'sd32768;
            round_q16 = s >>> Q16;
        end
    endfunction

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647)
                sat_vel = 32'sh7FFFFFFF;
            else if (v < -64'sd2147483648)
                sat_vel = 32'sh80000000;
            else
                sat_vel = v[VEL_W-1:0];
        end
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
        begin
            if (v < 0)
                sat_pos = '0;
            else if (v > 40'sd268435455)
                sat_pos = '1;
            else
                sat_pos = v[POS_W-1:0];
        end
    endfunction

    function automatic logic [VEL_W-1:0] mag_vel(input logic signed [VEL_W-1:0] v);
        begin
            mag_vel = v[VEL_W-1] ? VEL_W'(-v) : v;
        end
    endfunction

endpackage
`default_nettype wire

FILE: sv/bps_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on bps_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none
module bps_mul
    import bps_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      go,
    input  wire logic [MUL_A_W-1:0]        a,
    input  wire logic [MUL_B_W-1:0]        b,
    input  wire logic                      neg,
    output logic signed [63:0]             prod,
    output unit_status_t                   status
);

    localparam int CNT_W = $clog2(MUL_B_W + 1);

    logic [MUL_A_W-1:0] a_reg, a_next;
    logic [MUL_A_W-1:0] hi_reg, hi_next;
    logic [MUL_B_W-1:0] lo_reg, lo_next;
    logic               neg_reg, neg_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [MUL_A_W:0]   sum;
    logic [MUL_P_W-1:0] mag;

    always_comb
    begin
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);
        if (go)
        begin
            a_next    = a;
            hi_next   = '0;
            lo_next   = b;
            neg_next  = neg;
            cnt_next  = CNT_W'(MUL_B_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            hi_next  = sum[MUL_A_W:1];
            lo_next  = {sum[0], lo_reg[MUL_B_W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        neg_reg <= neg_next;
    end

    assign mag         = {hi_reg, lo_reg};
    assign prod        = neg_reg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
`default_nettype wire

FILE: sv/bps_sqrt.sv
// Digit-by-digit integer square root, two radicand bits and one root bit per cycle.
// Depends on bps_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module bps_sqrt
    import bps_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  go,
    input  wire logic [SQ_IN_W-1:0]    radicand,
    output logic [SQ_OUT_W-1:0]        root,
    output unit_status_t               status
);

    localparam int REM_W = SQ_OUT_W + 3;
    localparam int CNT_W = $clog2(SQ_OUT_W + 1);

    logic [SQ_IN_W-1:0]  v_reg, v_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [SQ_OUT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [REM_W-1:0]    rem_sh;
    logic [REM_W-1:0]    trial;

    always_comb
    begin
        v_next    = v_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh = {rem_reg[REM_W-3:0], v_reg[SQ_IN_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        if (go)
        begin
            v_next    = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(SQ_OUT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            v_next   = {v_reg[SQ_IN_W-3:0], 2'b00};
            cnt_next = cnt_reg - 1'b1;
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[SQ_OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[SQ_OUT_W-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root        = root_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
`default_nettype wire

FILE: sv/bps_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bps_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module bps_div
    import bps_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 go,
    input  wire logic [DIV_N_W-1:0]   numer,
    input  wire logic [DIV_D_W-1:0]   denom,
    output logic [DIV_N_W-1:0]        quot,
    output unit_status_t              status
);

    localparam int REM_W = DIV_D_W + 1;
    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic [DIV_N_W-1:0] n_reg, n_next;
    logic [DIV_D_W-1:0] d_reg, d_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [DIV_N_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [REM_W-1:0]   rem_sh;

    always_comb
    begin
        n_next    = n_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh = {rem_reg[REM_W-2:0], n_reg[DIV_N_W-1]};
        if (go)
        begin
            n_next    = numer;
            d_next    = denom;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = CNT_W'(DIV_N_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next   = {n_reg[DIV_N_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (rem_sh >= {1'b0, d_reg})
            begin
                rem_next = rem_sh - {1'b0, d_reg};
                q_next   = {q_reg[DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[DIV_N_W-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign quot        = q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
`default_nettype wire

FILE: sv/ball_physics_step.sv
// Top level of the ball physics step: sequencer, state, configuration and output register.
// Depends on bps_pkg, bps_mul, bps_sqrt and bps_div.
`timescale 1ns / 1ps
`default_nettype none
// One transfer on the input channel advances the ball by one Euler step of dt seconds
// and yields exactly one transfer on the output channel with the new position and
// speed. Gravity is added to the vertical speed; when the target lies more than one
// pixel away a pull of the configured pull gain times dt along the unit direction to
// the target is added, then the ball moves, the horizontal speed is damped, and each
// wall clamps the position and reverses that speed scaled by restitution. All
// multiplies, square roots and divides run through three bit-serial units shared by a
// sequencer: a shift-and-add multiplier and a square root of 29 iterations each, and
// a divider of 58 iterations. The input is stalled for the whole step; the next input
// transfer can be taken in the cycle after the result is loaded. A finished result
// sits in the output register and the next input transfer is taken while it waits; a
// result that is still waiting when the next step finishes holds the sequencer in its
// final state.
// Configuration writes must be made only while the block is idle.
module ball_physics_step
    import bps_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [15:0]             dt,
    input  wire logic [POS_W-1:0]        target_x,
    input  wire logic [POS_W-1:0]        target_y,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [POS_W-1:0]             pos_x,
    output logic [POS_W-1:0]             pos_y,
    output logic signed [VEL_W-1:0]      vel_x,
    output logic signed [VEL_W-1:0]      vel_y,
    input  wire logic                    cfg_we,
    input  wire logic [2:0]              cfg_index,
    input  wire logic [27:0]             cfg_data
);

    // Reset values follow the default geometry, saturated to the register width.
    localparam longint GRAV_RAW  = longint'(400) << FRAC_BITS;
    localparam longint PULL_RAW  = longint'(150) << FRAC_BITS;
    localparam longint BX_RAW    = longint'(320) << FRAC_BITS;
    localparam longint BY_RAW    = longint'(120) << FRAC_BITS;
    localparam longint SX_RAW    = longint'(120) << FRAC_BITS;
    localparam longint POS_LIM   = 268435455;
    localparam logic [POS_W-1:0] GRAV_RST = (GRAV_RAW > POS_LIM) ? '1 : POS_W'(GRAV_RAW);
    localparam logic [POS_W-1:0] PULL_RST = (PULL_RAW > POS_LIM) ? '1 : POS_W'(PULL_RAW);
    localparam logic [POS_W-1:0] BX_RST   = (BX_RAW > POS_LIM) ? '1 : POS_W'(BX_RAW);
    localparam logic [POS_W-1:0] BY_RST   = (BY_RAW > POS_LIM) ? '1 : POS_W'(BY_RAW);
    localparam logic [VEL_W-1:0] SX_RST   = (SX_RAW > 2147483647) ? 32'h7FFFFFFF
                                                                  : VEL_W'(SX_RAW);
    // The pull applies only beyond one pixel, compared on the squared distance.
    localparam logic [SQ_IN_W-1:0] NEAR_LIM = SQ_IN_W'(1) << (2 * FRAC_BITS);

    // Configuration registers.
    logic [11:0]      arena_w_reg;
    logic [11:0]      arena_h_reg;
    logic [10:0]      radius_reg;
    logic [POS_W-1:0] gravity_reg;
    logic [POS_W-1:0] pull_reg;
    logic [15:0]      damping_reg;
    logic [15:0]      restitution_reg;

    // Ball state, updated when a result is loaded.
    logic [POS_W-1:0]        ball_x_reg, ball_x_next;
    logic [POS_W-1:0]        ball_y_reg, ball_y_next;

    // Per-step working registers.
    state_t                  state_reg, state_next;
    logic                    run_reg, run_next;
    logic [15:0]             dt_reg;
    logic [POS_W-1:0]        tx_reg, ty_reg;
    logic signed [VEL_W-1:0] sx_reg, sx_next;
    logic signed [VEL_W-1:0] sy_reg, sy_next;
    logic [SQ_IN_W-1:0]      d2_reg, d2_next;
    logic [SQ_OUT_W-1:0]     dist_reg, dist_next;
    logic [POS_W-1:0]        t_reg, t_next;
    logic [DIV_N_W-1:0]      num_reg, num_next;
    logic signed [WIDE_W-1:0] x_reg, x_next;
    logic signed [WIDE_W-1:0] y_reg, y_next;
    logic                    bx_reg, bx_next;
    logic                    by_reg, by_next;

    // Output register.
    logic                    out_valid_reg, out_valid_next;
    logic [POS_W-1:0]        pos_x_reg, pos_y_reg;
    logic signed [VEL_W-1:0] vel_x_reg, vel_y_reg;
    logic                    out_load;

    // Unit connections.
    logic                    mul_go, sqrt_go, div_go;
    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic                    mul_neg;
    logic signed [63:0]      mul_p;
    logic signed [63:0]      mul_r;
    logic [SQ_OUT_W-1:0]     sqrt_root;
    logic [DIV_N_W-1:0]      div_q;
    unit_status_t            mul_st, sqrt_st, div_st;

    logic signed [POS_W:0]   dx, dy;
    logic [POS_W:0]          adx, ady;
    logic signed [WIDE_W-1:0] rad_w, arena_w, arena_h;
    logic in_xfer;

    assign in_xfer = in_valid && !in_stall;

    assign dx  = $signed({1'b0, tx_reg}) - $signed({1'b0, ball_x_reg});
    assign dy  = $signed({1'b0, ty_reg}) - $signed({1'b0, ball_y_reg});
    assign adx = dx[POS_W] ? (POS_W+1)'(-dx) : dx;
    assign ady = dy[POS_W] ? (POS_W+1)'(-dy) : dy;

    assign rad_w   = $signed(WIDE_W'(radius_reg) << FRAC_BITS);
    assign arena_w = $signed(WIDE_W'(arena_w_reg) << FRAC_BITS);
    assign arena_h = $signed(WIDE_W'(arena_h_reg) << FRAC_BITS);

    assign mul_r = round_q16(mul_p);

    bps_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (mul_go),
        .a      (mul_a),
        .b      (mul_b),
        .neg    (mul_neg),
        .prod   (mul_p),
        .status (mul_st)
    );

    bps_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (sqrt_go),
        .radicand (d2_reg),
        .root     (sqrt_root),
        .status   (sqrt_st)
    );

    bps_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (div_go),
        .numer  (num_reg),
        .denom  (dist_reg),
        .quot   (div_q),
        .status (div_st)
    );

    // Sequencer. Each arithmetic state starts its unit on the first cycle, then
    // waits for the done pulse and folds the result into the working registers.
    always_comb
    begin
        state_next  = state_reg;
        run_next    = run_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        d2_next     = d2_reg;
        dist_next   = dist_reg;
        t_next      = t_reg;
        num_next    = num_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        ball_x_next = ball_x_reg;
        ball_y_next = ball_y_reg;
        mul_go      = 1'b0;
        sqrt_go     = 1'b0;
        div_go      = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        mul_neg     = 1'b0;
        out_load    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_GRAV;
                    run_next   = 1'b0;
                end
            end
            ST_GRAV:
            begin
                mul_a = MUL_A_W'(gravity_reg);
                mul_b = MUL_B_W'(dt_reg);
                if (!run_reg)
                begin
                    mul_go   = 1'b1;
                    run_next = 1'b1;
                end
                else if (mul_st.done)
                begin
                    run_next   = 1'b0;
                    sy_next    = sat_vel(64'(sy_reg) + mul_r);
                    state_next = ST_DX2;
                end
            end
            ST_DX2:
            begin
                mul_a = MUL_A_W'(adx);
                mul_b = MUL_B_W'(adx);
                if (!run_reg)
                begin
                    mul_go   = 1'b1;
                    run_next = 1'b1;
                end
                else if (mul_st.done)
                begin
                    run_next   = 1'b0;
                    d2_next    = SQ_IN_W'(mul_p);
                    state_next = ST_DY2;
                end
            end
            ST_DY2:
            begin
                mul_a = MUL_A_W'(ady);
                mul_b = MUL_B_W'(ady);
                if (!run_reg)
                begin
                    mul_go   = 1'b1;
                    run_next = 1'b1;
                end
                else if (mul_st.done)
                begin
                    run_next   = 1'b0;
                    d2_next    = d2_reg + SQ_IN_W'(mul_p);
                    state_next = (d2_next > NEAR_LIM) ? ST_SQRT : ST_MOVX;
                end
            end
            ST_SQRT:
            begin
                if (!run_reg)
                begin
                    sqrt_go  = 1'b1;
                    run_next = 1'b1;
                end
                else if (sqrt_st.done)
                begin
                    run_next   = 1'b0;
                    dist_next  = sqrt_root;
                    state_next = ST_PULL;
                end
            end
            ST_PULL:
            begin
                mul_a = MUL_A_W'(pull_reg);
                mul_b = MUL_B_W'(dt_reg);
                if (!run_reg)
                begin
                    mul_go   = 1'b1;
                    run_next = 1'b1;
                end
                else if (mul_st.done)
                begin
                    run_next   = 1'b0;
                    t_next     = POS_W'(mul_r);
                    state_next = ST_NUMX;
                end
            end
            ST_NUMX, ST_NUMY:
            begin
                mul_a = (state_reg == ST_NUMX) ? MUL_A_W'(adx) : MUL_A_W'(ady);
                mul_b = MUL_B_W'(t_reg);
                if (!run_reg)
                begin
                    mul_go   = 1'b1;
                    run_next = 1'b1;
                end
                else if (mul_st.done)
                begin
                    // Add half the divisor so the divide rounds to nearest.
                    run_next   = 1'b0;
                    num_next   = DIV_N_W'(mul_p) + DIV_N_W'(dist_reg >> 1);
                    state_next = (state_reg == ST_NUMX) ? ST_DIVX : ST_DIVY;
                end
            end
            ST_DIVX:
            begin
                if (!run_reg)
                begin
                    div_go   = 1'b1;
                    run_next = 1'b1;
                end
                else if (div_st.done)
                begin
                    run_next   = 1'b0;
                    sx_next    = sat_vel(dx[POS_W] ? 64'(sx_reg) - $signed(64'(div_q))
                                                   : 64'(sx_reg) + $signed(64'(div_q)));
                    state_next = ST_NUMY;
                end
            end
            ST_DIVY:
            begin
                if (!run_reg)
                begin
                    div_go   = 1'b1;
                    run_next = 1'b1;
                end
                else if (div_st.done)
                begin
                    run_next   = 1'b0;
                    sy_next    = sat_vel(dy[POS_W] ? 64'(sy_reg) - $signed(64'(div_q))
                                                   : 64'(sy_reg) + $signed(64'(div_q)));
                    state_next = ST_MOVX;
                end
            end
            ST_MOVX:
            begin
                mul_a   = MUL_A_W'(mag_vel(sx_reg));
                mul_b   = MUL_B_W'(dt_reg);
                mul_neg = sx_reg[VEL_W-1];
                if (!run_reg)
                begin
                    mul_go   = 1'b1;
                    run_next = 1'b1;
                end
                else if (mul_st.done)
                begin
                    run_next   = 1'b0;
                    x_next     = $signed(WIDE_W'(ball_x_reg)) + WIDE_W'(mul_r);
                    state_next = ST_MOVY;
                end
            end
            ST_MOVY:
            begin
                mul_a   = MUL_A_W'(mag_vel(sy_reg));
                mul_b   = MUL_B_W'(dt_reg);
                mul_neg = sy_reg[VEL_W-1];
                if (!run_reg)
                begin
                    mul_go   = 1'b1;
                    run_next = 1'b1;
                end
                else if (mul_st.done)
                begin
                    run_next   = 1'b0;
                    y_next     = $signed(WIDE_W'(ball_y_reg)) + WIDE_W'(mul_r);
                    state_next = ST_DAMP;
                end
            end
            ST_DAMP:
            begin
                mul_a   = MUL_A_W'(mag_vel(sx_reg));
                mul_b   = MUL_B_W'(damping_reg);
                mul_neg = sx_reg[VEL_W-1];
                if (!run_reg)
                begin
                    mul_go   = 1'b1;
                    run_next = 1'b1;
                end
                else if (mul_st.done)
                begin
                    run_next   = 1'b0;
                    sx_next    = sat_vel(mul_r);
                    state_next = ST_WALL;
                end
            end
            ST_WALL:
            begin
                // Left and top are checked first; right and bottom only otherwise.
                bx_next = 1'b0;
                by_next = 1'b0;
                if (x_reg - rad_w < 0)
                begin
                    x_next  = rad_w;
                    bx_next = 1'b1;
                end
                else if (x_reg + rad_w > arena_w)
                begin
                    x_next  = arena_w - rad_w;
                    bx_next = 1'b1;
                end
                if (y_reg - rad_w < 0)
                begin
                    y_next  = rad_w;
                    by_next = 1'b1;
                end
                else if (y_reg + rad_w > arena_h)
                begin
                    y_next  = arena_h - rad_w;
                    by_next = 1'b1;
                end
                state_next = bx_next ? ST_RSTX : (by_next ? ST_RSTY : ST_FIN);
            end
            ST_RSTX:
            begin
                mul_a   = MUL_A_W'(mag_vel(sx_reg));
                mul_b   = MUL_B_W'(restitution_reg);
                mul_neg = !sx_reg[VEL_W-1];
                if (!run_reg)
                begin
                    mul_go   = 1'b1;
                    run_next = 1'b1;
                end
                else if (mul_st.done)
                begin
                    run_next   = 1'b0;
                    sx_next    = sat_vel(mul_r);
                    state_next = by_reg ? ST_RSTY : ST_FIN;
                end
            end
            ST_RSTY:
            begin
                mul_a   = MUL_A_W'(mag_vel(sy_reg));
                mul_b   = MUL_B_W'(restitution_reg);
                mul_neg = !sy_reg[VEL_W-1];
                if (!run_reg)
                begin
                    mul_go   = 1'b1;
                    run_next = 1'b1;
                end
                else if (mul_st.done)
                begin
                    run_next   = 1'b0;
                    sy_next    = sat_vel(mul_r);
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // Wait until the output register is free, then load it.
                if (!out_valid_reg || !out_stall)
                begin
                    out_load    = 1'b1;
                    ball_x_next = sat_pos(x_reg);
                    ball_y_next = sat_pos(y_reg);
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                run_next   = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            run_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            ball_x_reg      <= BX_RST;
            ball_y_reg      <= BY_RST;
            sx_reg          <= SX_RST;
            sy_reg          <= '0;
            arena_w_reg     <= 12'd640;
            arena_h_reg     <= 12'd480;
            radius_reg      <= 11'd25;
            gravity_reg     <= GRAV_RST;
            pull_reg        <= PULL_RST;
            damping_reg     <= 16'd64881;
            restitution_reg <= 16'd52429;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
            ball_x_reg    <= ball_x_next;
            ball_y_reg    <= ball_y_next;
            sx_reg        <= sx_next;
            sy_reg        <= sy_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ARENA_W:   arena_w_reg     <= cfg_data[11:0];
                    REG_ARENA_H:   arena_h_reg     <= cfg_data[11:0];
                    REG_RADIUS:    radius_reg      <= cfg_data[10:0];
                    REG_GRAVITY:   gravity_reg     <= cfg_data;
                    REG_PULL:      pull_reg        <= cfg_data;
                    REG_DAMPING:   damping_reg     <= cfg_data[15:0];
                    REG_RESTITUTE: restitution_reg <= cfg_data[15:0];
                    default:       ;
                endcase
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            dt_reg <= dt;
            tx_reg <= target_x;
            ty_reg <= target_y;
        end
        d2_reg   <= d2_next;
        dist_reg <= dist_next;
        t_reg    <= t_next;
        num_reg  <= num_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        if (out_load)
        begin
            pos_x_reg <= ball_x_next;
            pos_y_reg <= ball_y_next;
            vel_x_reg <= sx_reg;
            vel_y_reg <= sy_reg;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign vel_x     = vel_x_reg;
    assign vel_y     = vel_y_reg;

    // An accepted item always starts the sequencer.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_GRAV))
        else $error("accepted item did not start the step");

    // A new result appears only from the final state.
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load |-> (state_reg == ST_FIN)))
        else $error("result loaded outside the final state");

    // The multiplier is never restarted while it is still running.
    a_mul_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mul_go |-> !mul_st.busy)
        else $error("multiplier started while busy");

    // A square root or divide only runs inside an accepted step.
    a_units_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        (sqrt_go || div_go) |-> (state_reg != ST_IDLE) && !sqrt_st.busy && !div_st.busy)
        else $error("serial unit started out of sequence");

endmodule
`default_nettype wire
